// File: rtl/core/nearest_palette_color_search_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette color search
// Shared macros that keep the concurrent assertions short and uniform.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Widths, request codes and sequencer states of the nearest color search.
// ----------------------------------------------------------------------------
package npcs_pkg;

	localparam int COLOR_W = 16;
	localparam int CH_W    = 8;
	localparam int SQ_W    = 2 * CH_W;
	localparam int DIST_W  = 18;
	localparam int IDX_W   = 8;

	localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_HOLD   = 4'b1000
	} state_t;

endpackage

// File: rtl/core/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module npcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/npcs_dist.sv
// ----------------------------------------------------------------------------
// npcs_dist
// Two-stage squared distance unit shared by every palette entry of a search.
// ----------------------------------------------------------------------------
module npcs_dist
	import npcs_pkg::*;
#(
	parameter int AW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flush,
	input  logic               in_vld,
	input  logic               in_last,
	input  logic [AW-1:0]      in_idx,
	input  logic [COLOR_W-1:0] color,
	input  logic [CH_W-1:0]    q_red,
	input  logic [CH_W-1:0]    q_green,
	input  logic [CH_W-1:0]    q_blue,
	output logic               out_vld,
	output logic               out_last,
	output logic [AW-1:0]      out_idx,
	output logic [DIST_W-1:0]  out_dist
);

	logic [CH_W-1:0] c_red, c_green, c_blue;
	logic [CH_W-1:0] d_red, d_green, d_blue;
	logic [SQ_W-1:0] sq_red_s2, sq_green_s2, sq_blue_s2;
	logic            vld_s2, last_s2, vld_s3, last_s3;
	logic [AW-1:0]   idx_s2, idx_s3;
	logic [DIST_W-1:0] dist_s3;

	// Stored components are expanded with zero low bits.
	assign c_red   = {color[15:11], 3'b000};
	assign c_green = {color[10:5], 2'b00};
	assign c_blue  = {color[4:0], 3'b000};

	assign d_red   = (q_red >= c_red) ? (q_red - c_red) : (c_red - q_red);
	assign d_green = (q_green >= c_green) ? (q_green - c_green) : (c_green - q_green);
	assign d_blue  = (q_blue >= c_blue) ? (q_blue - c_blue) : (c_blue - q_blue);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= in_vld && !flush;
			vld_s3 <= vld_s2 && !flush;
		end
	end

	always_ff @(posedge clk) begin
		sq_red_s2   <= SQ_W'(d_red) * SQ_W'(d_red);
		sq_green_s2 <= SQ_W'(d_green) * SQ_W'(d_green);
		sq_blue_s2  <= SQ_W'(d_blue) * SQ_W'(d_blue);
		idx_s2      <= in_idx;
		last_s2     <= in_last;
		dist_s3     <= DIST_W'(sq_red_s2) + DIST_W'(sq_green_s2) + DIST_W'(sq_blue_s2);
		idx_s3      <= idx_s2;
		last_s3     <= last_s2;
	end

	assign out_vld  = vld_s3;
	assign out_last = last_s3;
	assign out_idx  = idx_s3;
	assign out_dist = dist_s3;

endmodule

// File: rtl/core/nearest_palette_color_search_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// RGB565 palette store with a sequential nearest color search.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   --------  -------------------  ------------------------------------------
//   request   in_valid / in_stall  mode, entry_index, entry_color,
//                                  query_red, query_green, query_blue
//   result    out_valid/out_stall  best_index, best_distance
//
// A palette write request gives no result.
// A query walks the palette one entry per cycle through the single RAM read
// port and the shared distance unit; an exact match ends the walk as soon
// as its distance is compared.
// After reset a clearing pass zeroes every palette entry, and no request is
// taken until it is done.
// A result waits in the output register while out_stall is high; a finished
// query holds in its last state until that register is free.
//
`include "nearest_palette_color_search_top_defines.svh"

module nearest_palette_color_search_top
	import npcs_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [IDX_W-1:0]   entry_index,
	input  logic [COLOR_W-1:0] entry_color,
	input  logic [CH_W-1:0]    query_red,
	input  logic [CH_W-1:0]    query_green,
	input  logic [CH_W-1:0]    query_blue,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   best_index,
	output logic [DIST_W-1:0]  best_distance
);

	localparam int AW    = $clog2(PALETTE_ENTRIES);
	localparam int CMP_W = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

	state_t              state_q;
	logic [AW-1:0]       cnt_q;
	logic                issue_on_q;
	logic                cnt_last;
	logic [CH_W-1:0]     q_red_q, q_green_q, q_blue_q;

	logic                v_s1, last_s1;
	logic [AW-1:0]       idx_s1;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr;
	logic [COLOR_W-1:0]  ram_wdata, ram_rdata;

	logic                d_vld, d_last;
	logic [AW-1:0]       d_idx;
	logic [DIST_W-1:0]   d_dist;

	logic [AW-1:0]       best_idx_q;
	logic [DIST_W-1:0]   best_dist_q;
	logic                take;
	logic [AW-1:0]       new_idx;
	logic [DIST_W-1:0]   new_dist;
	logic                finish;

	logic                in_acc;
	logic                idx_ok;
	logic                out_valid_q, out_load;
	logic [IDX_W-1:0]    out_idx_q;
	logic [DIST_W-1:0]   out_dist_q;

	// Requests are taken only while the sequencer rests.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign cnt_last = (cnt_q == LAST_ADDR);

	// A write to a slot beyond the palette is dropped.
	assign idx_ok = (CMP_W'(entry_index) < CMP_W'(PALETTE_ENTRIES));

	// The clearing pass and palette writes share the single write port.
	assign ram_we    = (state_q == ST_CLEAR) || (in_acc && mode == MODE_WRITE && idx_ok);
	assign ram_waddr = (state_q == ST_CLEAR) ? cnt_q : AW'(entry_index);
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : entry_color;
	assign ram_re    = (state_q == ST_SEARCH) && issue_on_q;

	npcs_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	npcs_dist #(
		.AW (AW)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (finish),
		.in_vld   (v_s1),
		.in_last  (last_s1),
		.in_idx   (idx_s1),
		.color    (ram_rdata),
		.q_red    (q_red_q),
		.q_green  (q_green_q),
		.q_blue   (q_blue_q),
		.out_vld  (d_vld),
		.out_last (d_last),
		.out_idx  (d_idx),
		.out_dist (d_dist)
	);

	// Entry zero always seeds the best; later entries replace it only when
	// strictly closer, so the lowest index wins a tie.
	assign take     = (d_idx == '0) || (d_dist < best_dist_q);
	assign new_idx  = take ? d_idx : best_idx_q;
	assign new_dist = take ? d_dist : best_dist_q;

	// The walk ends at the last entry or once an exact match is the best.
	assign finish = (state_q == ST_SEARCH) && d_vld && (d_last || new_dist == '0);

	assign out_load = (state_q == ST_HOLD) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			issue_on_q  <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && mode == MODE_QUERY) begin
						cnt_q      <= '0;
						issue_on_q <= 1'b1;
						state_q    <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (finish) begin
						issue_on_q <= 1'b0;
						state_q    <= ST_HOLD;
					end else if (issue_on_q) begin
						v_s1  <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_last) begin
							issue_on_q <= 1'b0;
						end
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					issue_on_q <= 1'b0;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && mode == MODE_QUERY) begin
			q_red_q   <= query_red;
			q_green_q <= query_green;
			q_blue_q  <= query_blue;
		end
		idx_s1  <= cnt_q;
		last_s1 <= cnt_last;
		if (state_q == ST_SEARCH && d_vld) begin
			best_idx_q  <= new_idx;
			best_dist_q <= new_dist;
		end
		if (out_load) begin
			out_idx_q  <= IDX_W'(best_idx_q);
			out_dist_q <= best_dist_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_index    = out_idx_q;
	assign best_distance = out_dist_q;

	`NPCS_ASSERT_NOW(a_dist_only_in_search, clk, arst_n,
		d_vld, state_q == ST_SEARCH, "distance result outside of a search")
	`NPCS_ASSERT_NOW(a_write_when_quiet, clk, arst_n,
		ram_we, state_q == ST_CLEAR || state_q == ST_IDLE, "palette written during a search")
	`NPCS_ASSERT_NEXT(a_finish_to_hold, clk, arst_n,
		finish, state_q == ST_HOLD && !issue_on_q, "search did not stop after its end")
	`NPCS_ASSERT_NOW(a_result_in_range, clk, arst_n,
		out_valid, best_distance <= DIST_MAX, "result distance out of range")

endmodule

// File: verif/nearest_palette_color_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette color search testbench
// Sends palette writes and color queries through the valid/stall request
// channel and predicts each query's nearest slot and squared distance from a
// shadow copy of the palette. Results are checked in order, field by field,
// while both channels idle and stall at several rates.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top_tb;
	import npcs_pkg::*;

	localparam int PAL_SLOTS      = 256;
	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 10;
	localparam int LONG_HOLD      = 1500;
	localparam int SETTLE_CYCLES  = PAL_SLOTS + 16;
	localparam int REPORT_LIMIT   = 10;
	// The slowest correct run is about 420 requests that each walk the whole
	// palette, plus the clearing pass, the long hold and the random gaps.
	// The limit below is several times that.
	localparam int TIMEOUT_CYCLES = 600000;

	typedef struct packed {
		logic               mode;
		logic [IDX_W-1:0]   entry_index;
		logic [COLOR_W-1:0] entry_color;
		logic [CH_W-1:0]    query_red;
		logic [CH_W-1:0]    query_green;
		logic [CH_W-1:0]    query_blue;
	} palette_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance;
	} nearest_match_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               mode = MODE_WRITE;
	logic [IDX_W-1:0]   entry_index = '0;
	logic [COLOR_W-1:0] entry_color = '0;
	logic [CH_W-1:0]    query_red = '0;
	logic [CH_W-1:0]    query_green = '0;
	logic [CH_W-1:0]    query_blue = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [IDX_W-1:0]   best_index;
	logic [DIST_W-1:0]  best_distance;

	// Requests waiting to be offered, and the matches still owed by the block.
	palette_req_t   pending_reqs[$];
	nearest_match_t expected_matches[$];

	// Shadow of the palette as the block sees it, updated at acceptance.
	logic [COLOR_W-1:0] palette_model[PAL_SLOTS];
	// Colors written so far, used to build exact and near queries.
	logic [COLOR_W-1:0] written_colors[$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_orders = 0;
	int  mismatches = 0;
	logic req_taken = 1'b0;

	nearest_palette_color_search_top #(
		.PALETTE_ENTRIES(PAL_SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.entry_index  (entry_index),
		.entry_color  (entry_color),
		.query_red    (query_red),
		.query_green  (query_green),
		.query_blue   (query_blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.best_index   (best_index),
		.best_distance(best_distance)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Squared distance between a stored RGB565 color and an 8-bit query.
	// The stored components are widened by shifting, so their low bits are zero.
	function automatic int unsigned color_distance(input logic [COLOR_W-1:0] c,
			input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		int dr;
		int dg;
		int db;
		dr = int'(r) - int'({c[15:11], 3'b000});
		dg = int'(g) - int'({c[10:5], 2'b00});
		db = int'(b) - int'({c[4:0], 3'b000});
		return dr * dr + dg * dg + db * db;
	endfunction

	// Walks the shadow palette from slot 0 upward. Only a strictly smaller
	// distance replaces the best, so ties keep the lowest slot, and an exact
	// match ends the walk.
	function automatic nearest_match_t find_nearest(input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		nearest_match_t m;
		int unsigned best_d;
		int unsigned d;
		int i;
		best_d = color_distance(palette_model[0], r, g, b);
		m.best_index = '0;
		for (i = 1; i < PAL_SLOTS && best_d != 0; i++) begin
			d = color_distance(palette_model[i], r, g, b);
			if (d < best_d) begin
				best_d = d;
				m.best_index = i[IDX_W-1:0];
			end
		end
		m.best_distance = best_d[DIST_W-1:0];
		return m;
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] %s", $time, what);
	endtask

	// A write request carries random query fields, which the block must ignore.
	task automatic push_write(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] color);
		palette_req_t req;
		req.mode        = MODE_WRITE;
		req.entry_index = idx;
		req.entry_color = color;
		req.query_red   = 8'($urandom_range(0, 255));
		req.query_green = 8'($urandom_range(0, 255));
		req.query_blue  = 8'($urandom_range(0, 255));
		pending_reqs.push_back(req);
		written_colors.push_back(color);
	endtask

	// A query request carries random entry fields, which the block must ignore.
	task automatic push_query(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		palette_req_t req;
		req.mode        = MODE_QUERY;
		req.entry_index = 8'($urandom_range(0, 255));
		req.entry_color = 16'($urandom_range(0, 65535));
		req.query_red   = r;
		req.query_green = g;
		req.query_blue  = b;
		pending_reqs.push_back(req);
	endtask

	// Mostly palette writes followed by queries aimed at written colors, so that
	// exact matches end walks at many depths and duplicate colors force ties.
	// The rest is fully random queries.
	task automatic add_random_traffic(input int count);
		logic [COLOR_W-1:0] c;
		int kind;
		repeat (count) begin
			kind = $urandom_range(0, 99);
			c = written_colors[$urandom_range(0, written_colors.size() - 1)];
			if (kind < 35) begin
				push_write(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
			end else if (kind < 45) begin
				// The same color in a second slot creates a tie.
				push_write(8'($urandom_range(0, 255)), c);
			end else if (kind < 65) begin
				push_query({c[15:11], 3'b000}, {c[10:5], 2'b00}, {c[4:0], 3'b000});
			end else if (kind < 80) begin
				// Low bits that the palette cannot hold give a small, usually nonzero distance.
				push_query({c[15:11], 3'($urandom_range(0, 7))},
					{c[10:5], 2'($urandom_range(0, 3))},
					{c[4:0], 3'($urandom_range(0, 7))});
			end else begin
				push_query(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Waits until every request has been taken and every match has come back.
	// The sender keeps offering the remaining requests during this wait.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_matches.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		add_random_traffic(count);
		wait_drained();
	endtask

	// Request driver. A new request is presented only when the channel is
	// empty or the current request was taken at the last rising edge, so a
	// stalled request keeps its valid and payload unchanged.
	always @(negedge clk) begin
		palette_req_t req;
		if (arst_n && (!in_valid || req_taken)) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req = pending_reqs.pop_front();
				in_valid    <= 1'b1;
				mode        <= req.mode;
				entry_index <= req.entry_index;
				entry_color <= req.entry_color;
				query_red   <= req.query_red;
				query_green <= req.query_green;
				query_blue  <= req.query_blue;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver. A long hold, once ordered, is counted down here while
	// the sender keeps offering requests; otherwise the stall is random.
	always @(negedge clk) begin
		int holds_served;
		int hold_left;
		if (hold_orders != holds_served) begin
			holds_served = hold_orders;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Monitor. On each accepted request the shadow palette is updated or the
	// expected match is computed; each accepted result is compared with the
	// oldest expected match.
	always @(posedge clk) begin
		nearest_match_t want;
		req_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (mode == MODE_WRITE) begin
					if (int'(entry_index) < PAL_SLOTS)
						palette_model[entry_index] = entry_color;
				end else begin
					expected_matches.push_back(find_nearest(query_red, query_green, query_blue));
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_matches.size() == 0) begin
					note_mismatch($sformatf("unexpected result index %0d distance %0d",
						best_index, best_distance));
				end else begin
					want = expected_matches.pop_front();
					if (best_index !== want.best_index || best_distance !== want.best_distance)
						note_mismatch($sformatf(
							"expected index %0d distance %0d, got index %0d distance %0d",
							want.best_index, want.best_distance, best_index, best_distance));
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		foreach (palette_model[i])
			palette_model[i] = '0;
		// The palette is all zero after reset, and black is its only color.
		written_colors.push_back('0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests. An empty palette matches black exactly at slot 0,
		// and white ties on every slot at the largest possible distance.
		push_query(8'd0, 8'd0, 8'd0);
		push_query(8'd255, 8'd255, 8'd255);
		// A lone white entry in the last slot is found only at the end of the walk.
		push_write(8'd255, 16'hFFFF);
		push_query(8'd255, 8'd255, 8'd255);
		push_query(8'd248, 8'd252, 8'd248);
		// The same color in slot 0 ends the walk on the first entry.
		push_write(8'd0, 16'hFFFF);
		push_query(8'd248, 8'd252, 8'd248);
		// Pure primaries in the middle of the palette.
		push_write(8'd128, 16'hF800);
		push_write(8'd129, 16'h07E0);
		push_write(8'd130, 16'h001F);
		push_query(8'd255, 8'd0, 8'd0);
		push_query(8'd0, 8'd255, 8'd0);
		push_query(8'd0, 8'd0, 8'd255);
		// A later duplicate of red must lose the tie to the earlier slot.
		push_write(8'd200, 16'hF800);
		push_query(8'd255, 8'd3, 8'd7);
		// Alternating bit patterns in every field.
		push_write(8'hAA, 16'hAAAA);
		push_write(8'h55, 16'h5555);
		push_query(8'hAA, 8'h55, 8'hAA);
		push_query(8'h55, 8'hAA, 8'h55);
		push_query(8'd0, 8'd0, 8'd0);
		wait_drained();

		// Random phases: no idling, an idle sender, a stalling receiver, both.
		run_phase(0, 0, 90);
		run_phase(57, 0, 90);
		run_phase(0, 57, 90);
		run_phase(25, 25, 90);

		// Back pressure: the receiver holds off for a long stretch while the
		// sender offers requests at full rate, so the block fills and stalls
		// its request channel.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_orders++;
		add_random_traffic(40);
		wait_drained();

		// A trailing write may still be in progress, and nothing more may appear.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_matches.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_matches.size()));

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Mismatches found");
		$finish;
	end

endmodule
